[src/mp_pkg.sv]
package mp_pkg;

    localparam int MOD_W            = 31;
    localparam int DATA_W           = 32;
    localparam int EXP_BITS_DEFAULT = 32;
    localparam int MUL_BITS_DEFAULT = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(100000007);

    typedef struct packed {
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] exponent;
    } mp_in_t;

    typedef struct packed {
        logic [MOD_W-1:0] power;
        logic             reciprocal;
    } mp_out_t;

endpackage

[src/mp_mulmod.sv]
module mp_mulmod #(
    parameter int MUL_BITS = mp_pkg::MUL_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [mp_pkg::MOD_W-1:0] mcand,
    input  logic [MUL_BITS-1:0]      mplier,
    input  logic [mp_pkg::MOD_W-1:0] modulus,
    output logic                     done,
    output logic [mp_pkg::MOD_W-1:0] result
);
    import mp_pkg::*;

    localparam int CNT_W = (MUL_BITS > 1) ? $clog2(MUL_BITS) : 1;

    logic                busy_reg, busy_next;
    logic                phase_reg, phase_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic [MOD_W-1:0]    mcand_reg, mcand_next;
    logic [MUL_BITS-1:0] mplier_reg, mplier_next;

    logic [MOD_W-1:0]    addend;
    logic [MOD_W:0]      sum;
    logic [MOD_W:0]      diff;
    logic [MOD_W-1:0]    r_step;

    // For each multiplier bit: first r = 2r mod m, then r = r + bit*a mod m.
    always_comb begin
        addend = phase_reg ? (mplier_reg[MUL_BITS-1] ? mcand_reg : '0) : r_reg;
        sum    = {1'b0, r_reg} + {1'b0, addend};
        diff   = sum - {1'b0, modulus};
        r_step = (sum >= {1'b0, modulus}) ? diff[MOD_W-1:0] : sum[MOD_W-1:0];
    end

    always_comb begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            phase_next  = 1'b0;
            cnt_next    = '0;
            r_next      = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
        end else if (busy_reg) begin
            r_next     = r_step;
            phase_next = ~phase_reg;
            if (phase_reg) begin
                mplier_next = {mplier_reg[MUL_BITS-2:0], 1'b0};
                if (cnt_reg == CNT_W'(MUL_BITS - 1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        r_reg      <= r_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[src/modular_power.sv]
// Modular exponentiation: power = base ^ |exponent| mod modulus.
// The input channel (s_valid, s_ready, s_data) takes a signed base and a signed
// exponent; the result channel (m_valid, m_ready, m_data) returns the power and
// a reciprocal flag, set for a negative exponent and a nonzero base.
// The modulus register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce it.
// A modulus of zero acts as one. One transaction is processed at a time.
// The base is first reduced by a bit-serial modular multiplier; then each of
// the EXP_BITS exponent bits takes another pass of two such multipliers
// running side by side. s_ready returns once the result has moved from ST_FIN
// into the output register, so no new transaction is accepted before then.
// A zero base or zero exponent skips the multipliers and goes through ST_FIN
// straight to the output register.
// A finished result sits in an output register, so a stalled receiver does not
// hold up the next transaction; only a second result waits until it is taken.
// Reset returns the block to idle with no pending result and loads the
// modulus with 100000007.
module modular_power #(
    parameter int EXP_BITS = mp_pkg::EXP_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  mp_pkg::mp_in_t           s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output mp_pkg::mp_out_t          m_data,
    input  logic                     cfg_wr_en,
    input  logic [mp_pkg::MOD_W-1:0] cfg_wr_data
);
    import mp_pkg::*;

    localparam int BIT_CNT_W = $clog2(EXP_BITS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_EXP    = 3'd2;
    localparam logic [2:0] ST_FIN    = 3'd3;

    logic [2:0]           state_reg, state_next;
    logic                 start_reg, start_next;
    logic                 out_valid_reg, out_valid_next;
    mp_out_t              out_data_reg, out_data_next;
    logic [MOD_W-1:0]     modulus_reg, modulus_next;
    logic [MOD_W-1:0]     acc_reg, acc_next;
    logic [MOD_W-1:0]     sq_reg, sq_next;
    logic [EXP_BITS-1:0]  exp_reg, exp_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DATA_W-1:0]    babs_reg, babs_next;
    logic                 bneg_reg, bneg_next;
    logic                 eneg_reg, eneg_next;
    logic [MOD_W-1:0]     power_reg, power_next;
    logic                 recip_reg, recip_next;

    logic [MOD_W-1:0]     mod_eff;
    logic [MOD_W-1:0]     one_mod;
    logic [DATA_W-1:0]    babs_in;
    logic [DATA_W-1:0]    emag_in;
    logic [MOD_W-1:0]     mcand_a;
    logic [DATA_W-1:0]    mplier_a;
    logic [DATA_W-1:0]    mplier_sq;
    logic                 done_a, done_b;
    logic [MOD_W-1:0]     res_a, res_b;
    logic                 accept;

    assign mod_eff   = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;
    assign one_mod   = (mod_eff == MOD_W'(1)) ? '0 : MOD_W'(1);
    assign babs_in   = s_data.base[DATA_W-1] ? $unsigned(-s_data.base)
                                             : $unsigned(s_data.base);
    assign emag_in   = s_data.exponent[DATA_W-1] ? $unsigned(-s_data.exponent)
                                                 : $unsigned(s_data.exponent);
    assign mplier_sq = {{(DATA_W - MOD_W){1'b0}}, sq_reg};
    assign mcand_a   = (state_reg == ST_REDUCE) ? one_mod : acc_reg;
    assign mplier_a  = (state_reg == ST_REDUCE) ? babs_reg : mplier_sq;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    mp_mulmod #(
        .MUL_BITS (DATA_W)
    ) u_mul_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .mcand   (mcand_a),
        .mplier  (mplier_a),
        .modulus (mod_eff),
        .done    (done_a),
        .result  (res_a)
    );

    mp_mulmod #(
        .MUL_BITS (DATA_W)
    ) u_mul_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg && (state_reg == ST_EXP)),
        .mcand   (sq_reg),
        .mplier  (mplier_sq),
        .modulus (mod_eff),
        .done    (done_b),
        .result  (res_b)
    );

    always_comb begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        modulus_next   = cfg_wr_en ? cfg_wr_data : modulus_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        bit_cnt_next   = bit_cnt_reg;
        babs_next      = babs_reg;
        bneg_next      = bneg_reg;
        eneg_next      = eneg_reg;
        power_next     = power_reg;
        recip_next     = recip_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.base == '0) begin
                        power_next = '0;
                        recip_next = 1'b0;
                        state_next = ST_FIN;
                    end else if (s_data.exponent == '0) begin
                        power_next = MOD_W'(1);
                        recip_next = 1'b0;
                        state_next = ST_FIN;
                    end else begin
                        babs_next    = babs_in;
                        bneg_next    = s_data.base[DATA_W-1];
                        eneg_next    = s_data.exponent[DATA_W-1];
                        exp_next     = EXP_BITS'(emag_in);
                        bit_cnt_next = '0;
                        start_next   = 1'b1;
                        state_next   = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (done_a) begin
                    sq_next    = (bneg_reg && (res_a != '0)) ? (mod_eff - res_a) : res_a;
                    acc_next   = one_mod;
                    start_next = 1'b1;
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (done_a && done_b) begin
                    acc_next = exp_reg[0] ? res_a : acc_reg;
                    sq_next  = res_b;
                    exp_next = exp_reg >> 1;
                    if (bit_cnt_reg == BIT_CNT_W'(EXP_BITS - 1)) begin
                        power_next = acc_next;
                        recip_next = eneg_reg;
                        state_next = ST_FIN;
                    end else begin
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        start_next   = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next           = 1'b1;
                    out_data_next.power      = power_reg;
                    out_data_next.reciprocal = recip_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            modulus_reg   <= modulus_next;
        end
        out_data_reg <= out_data_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        exp_reg      <= exp_next;
        bit_cnt_reg  <= bit_cnt_next;
        babs_reg     <= babs_next;
        bneg_reg     <= bneg_next;
        eneg_reg     <= eneg_next;
        power_reg    <= power_next;
        recip_reg    <= recip_next;
    end

endmodule
